FILE: hdl/averaged_battery_low_detector_macros.svh
// ----------------------------------------------------------------------------
// Averaged battery low detector: assertion macros
// Shared concurrent assertion forms for the detector modules.
// ----------------------------------------------------------------------------
`ifndef AVERAGED_BATTERY_LOW_DETECTOR_MACROS_SVH
`define AVERAGED_BATTERY_LOW_DETECTOR_MACROS_SVH

// Checked on every rising edge outside reset.
`define ABLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ABLD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/abld_pkg.sv
// ----------------------------------------------------------------------------
// Averaged battery low detector: package
// Field widths, scaling constants, register indexes and shared types.
// ----------------------------------------------------------------------------
package abld_pkg;

  localparam int ADC_W  = 12;
  localparam int PIN_W  = 12;
  localparam int BATT_W = 15;
  localparam int SEQ_W  = 8;
  localparam int THR_W  = 15;
  localparam int CONF_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;

  localparam int DEFAULT_SAMPLES = 4;
  localparam int ADC_MAX         = 4095;
  localparam int ADC_SPAN        = 4095;
  localparam int ADC_REF_MV      = 2500;
  localparam int DIVIDER_SCALE   = 11;
  localparam int QUEUE_DEPTH     = 2;

  // The scaled average avg * 2500 stays below 2^24.
  localparam int SCALED_W    = 24;
  localparam int PIN_SHIFT   = 24;
  localparam int PIN_RECIP_W = 13;
  localparam logic [PIN_RECIP_W-1:0] PIN_RECIP =
    PIN_RECIP_W'((1 << PIN_SHIFT) / ADC_SPAN);

  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM       = 1'b1;

  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 15'd6600;
  localparam logic [CONF_W-1:0] CONFIRM_RESET   = 8'd3;

  typedef struct packed {
    logic [THR_W-1:0]  low_threshold_mv;
    logic [CONF_W-1:0] confirm_readings;
  } cfg_t;

  typedef struct packed {
    logic [ADC_W-1:0]  adc_average;
    logic [PIN_W-1:0]  pin_mv;
    logic [BATT_W-1:0] battery_mv;
    logic              battery_low;
    logic [SEQ_W-1:0]  reading_sequence;
  } result_t;

endpackage

FILE: hdl/averaged_battery_low_detector.sv
// ----------------------------------------------------------------------------
// Averaged battery low detector: top level
// Groups ADC conversions into readings, averages and scales them to battery
// millivolts and flags a confirmed low battery.
//
//   Channel  Direction  Handshake         Payload
//   in       input      push / full       in_adc_sample
//   out      output     empty / pop       out_adc_average ... out_reading_sequence
//   cfg      input      cfg_wr_en         cfg_index, cfg_wdata
//
// The front end takes one conversion per cycle while full is low; a reading
// needs SAMPLES_PER_READING + 1 conversions. The back end steps each reading
// through its averaging and scaling sequencer and takes no new sum until it
// has emitted the last one. Reset is synchronous. Full rises when the
// two-entry sum queue holds two waiting sums; the back end holds its last step
// while the result register is occupied.
// ----------------------------------------------------------------------------
module averaged_battery_low_detector #(
  parameter int SAMPLES_PER_READING = abld_pkg::DEFAULT_SAMPLES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [abld_pkg::ADC_W-1:0]      in_adc_sample,
  output logic                            empty,
  input  logic                            pop,
  output logic [abld_pkg::ADC_W-1:0]      out_adc_average,
  output logic [abld_pkg::PIN_W-1:0]      out_pin_mv,
  output logic [abld_pkg::BATT_W-1:0]     out_battery_mv,
  output logic                            out_battery_low,
  output logic [abld_pkg::SEQ_W-1:0]      out_reading_sequence,
  input  logic                            cfg_wr_en,
  input  logic [abld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abld_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SUM_W = $clog2(SAMPLES_PER_READING * abld_pkg::ADC_MAX + 1);

  abld_pkg::cfg_t    cfg_r;
  abld_pkg::result_t res;
  logic              in_take;
  logic              out_take;
  logic              out_valid;
  logic              q_push;
  logic [SUM_W-1:0]  q_push_data;
  logic              q_pop;
  logic [SUM_W-1:0]  q_pop_data;
  logic              q_full;
  logic              q_empty;

  assign full     = q_full;
  assign in_take  = push && !q_full;
  assign empty    = !out_valid;
  assign out_take = pop && out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_threshold_mv <= abld_pkg::THRESHOLD_RESET;
      cfg_r.confirm_readings <= abld_pkg::CONFIRM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        abld_pkg::REG_LOW_THRESHOLD: begin
          cfg_r.low_threshold_mv <= cfg_wdata[abld_pkg::THR_W-1:0];
        end
        abld_pkg::REG_CONFIRM: begin
          cfg_r.confirm_readings <= cfg_wdata[abld_pkg::CONF_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  abld_front #(
    .SAMPLES_PER_READING(SAMPLES_PER_READING)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_take      (in_take),
    .in_adc_sample(in_adc_sample),
    .q_push       (q_push),
    .q_data       (q_push_data)
  );

  abld_queue #(
    .DATA_W(SUM_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .q_full   (q_full),
    .q_empty  (q_empty)
  );

  abld_back #(
    .SAMPLES_PER_READING(SAMPLES_PER_READING)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_pop_data),
    .q_pop    (q_pop),
    .cfg      (cfg_r),
    .out_take (out_take),
    .out_valid(out_valid),
    .out_res  (res)
  );

  assign out_adc_average      = res.adc_average;
  assign out_pin_mv           = res.pin_mv;
  assign out_battery_mv       = res.battery_mv;
  assign out_battery_low      = res.battery_low;
  assign out_reading_sequence = res.reading_sequence;

endmodule

FILE: hdl/abld_front.sv
// ----------------------------------------------------------------------------
// Averaged battery low detector: front end
// Drops the first conversion of each group and sums the kept conversions.
// ----------------------------------------------------------------------------
module abld_front #(
  parameter int SAMPLES_PER_READING = abld_pkg::DEFAULT_SAMPLES,
  localparam int SUM_W = $clog2(SAMPLES_PER_READING * abld_pkg::ADC_MAX + 1),
  localparam int POS_W = $clog2(SAMPLES_PER_READING + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_take,
  input  logic [abld_pkg::ADC_W-1:0] in_adc_sample,
  output logic                       q_push,
  output logic [SUM_W-1:0]           q_data
);

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;
  logic [SUM_W-1:0] sum_add;
  logic             last;

  assign sum_add = sum_r + SUM_W'(in_adc_sample);
  assign last    = (pos_r == POS_W'(SAMPLES_PER_READING));

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (in_take) begin
      if (pos_r == '0) begin
        pos_nxt = POS_W'(1);
        sum_nxt = '0;
      end else if (last) begin
        pos_nxt = '0;
        sum_nxt = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        sum_nxt = sum_add;
      end
    end
  end

  assign q_push = in_take && (pos_r != '0) && last;
  assign q_data = sum_add;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

FILE: hdl/abld_queue.sv
// ----------------------------------------------------------------------------
// Averaged battery low detector: sum queue
// Short first-in first-out queue of finished group sums.
// ----------------------------------------------------------------------------
module abld_queue #(
  parameter int DATA_W = 14,
  localparam int DEPTH = abld_pkg::QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              q_full,
  output logic              q_empty
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign q_full   = (count_r == CNT_W'(DEPTH));
  assign q_empty  = (count_r == '0);
  assign do_push  = push && !q_full;
  assign do_pop   = pop && !q_empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

FILE: hdl/abld_back.sv
// ----------------------------------------------------------------------------
// Averaged battery low detector: back end
// Averages a group sum, scales it to millivolts, tracks the low count and
// holds the finished result for transfer.
// ----------------------------------------------------------------------------
`include "averaged_battery_low_detector_macros.svh"

module abld_back #(
  parameter int SAMPLES_PER_READING = abld_pkg::DEFAULT_SAMPLES,
  localparam int SUM_W = $clog2(SAMPLES_PER_READING * abld_pkg::ADC_MAX + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  logic [SUM_W-1:0]  q_data,
  output logic              q_pop,
  input  abld_pkg::cfg_t    cfg,
  input  logic              out_take,
  output logic              out_valid,
  output abld_pkg::result_t out_res
);

  localparam int ADC_W    = abld_pkg::ADC_W;
  localparam int PIN_W    = abld_pkg::PIN_W;
  localparam int BATT_W   = abld_pkg::BATT_W;
  localparam int SEQ_W    = abld_pkg::SEQ_W;
  localparam int CONF_W   = abld_pkg::CONF_W;
  localparam int SCALED_W = abld_pkg::SCALED_W;
  localparam int AVG_PROD_W = 2 * SUM_W + 1;
  localparam int PIN_PROD_W = SCALED_W + abld_pkg::PIN_RECIP_W;

  localparam logic [SUM_W:0] AVG_RECIP =
    (SUM_W + 1)'((1 << SUM_W) / SAMPLES_PER_READING);
  localparam logic [SUM_W-1:0] AVG_DIV     = SUM_W'(SAMPLES_PER_READING);
  localparam logic [SUM_W-1:0] AVG_REM_LIM = SUM_W'(2 * SAMPLES_PER_READING);
  localparam logic [SCALED_W-1:0] PIN_DIV     = SCALED_W'(abld_pkg::ADC_SPAN);
  localparam logic [SCALED_W-1:0] PIN_REM_LIM = SCALED_W'(2 * abld_pkg::ADC_SPAN);
  localparam logic [PIN_W-1:0] PIN_MAX = PIN_W'(abld_pkg::ADC_REF_MV);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_AVG_EST = 3'd1;
  localparam logic [2:0] ST_AVG_FIX = 3'd2;
  localparam logic [2:0] ST_SCALE   = 3'd3;
  localparam logic [2:0] ST_PIN_EST = 3'd4;
  localparam logic [2:0] ST_PIN_FIX = 3'd5;
  localparam logic [2:0] ST_BATT    = 3'd6;
  localparam logic [2:0] ST_EMIT    = 3'd7;

  logic [2:0]          state_r;
  logic [2:0]          state_nxt;
  logic [SUM_W-1:0]    sum_r;
  logic [ADC_W-1:0]    avg_est_r;
  logic [ADC_W-1:0]    avg_r;
  logic [SCALED_W-1:0] scaled_r;
  logic [PIN_W-1:0]    pin_est_r;
  logic [PIN_W-1:0]    pin_r;
  logic [BATT_W-1:0]   batt_r;
  logic [CONF_W-1:0]   low_count_r;
  logic [CONF_W-1:0]   low_count_nxt;
  logic [SEQ_W-1:0]    seq_r;
  logic                out_valid_r;
  abld_pkg::result_t   out_res_r;

  logic [AVG_PROD_W-1:0] avg_prod;
  logic [SUM_W-1:0]      avg_rem;
  logic [PIN_PROD_W-1:0] pin_prod;
  logic [SCALED_W-1:0]   pin_rem;
  logic                  emit_go;
  logic                  is_low;

  assign avg_prod = AVG_PROD_W'(sum_r) * AVG_PROD_W'(AVG_RECIP);
  assign avg_rem  = sum_r - SUM_W'(avg_est_r) * AVG_DIV;
  assign pin_prod = PIN_PROD_W'(scaled_r) * PIN_PROD_W'(abld_pkg::PIN_RECIP);
  assign pin_rem  = scaled_r - SCALED_W'(pin_est_r) * PIN_DIV;

  assign q_pop   = (state_r == ST_IDLE) && !q_empty;
  assign emit_go = (state_r == ST_EMIT) && (!out_valid_r || out_take);
  assign is_low  = (batt_r < cfg.low_threshold_mv);

  always_comb begin
    if (is_low) begin
      low_count_nxt = (low_count_r < cfg.confirm_readings) ?
                      low_count_r + CONF_W'(1) : low_count_r;
    end else begin
      low_count_nxt = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_AVG_EST;
        end
      end
      ST_AVG_EST: state_nxt = ST_AVG_FIX;
      ST_AVG_FIX: state_nxt = ST_SCALE;
      ST_SCALE:   state_nxt = ST_PIN_EST;
      ST_PIN_EST: state_nxt = ST_PIN_FIX;
      ST_PIN_FIX: state_nxt = ST_BATT;
      ST_BATT:    state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sum_r <= q_data;
    end
    if (state_r == ST_AVG_EST) begin
      avg_est_r <= avg_prod[SUM_W +: ADC_W];
    end
    if (state_r == ST_AVG_FIX) begin
      avg_r <= avg_est_r + ADC_W'(avg_rem >= AVG_DIV);
    end
    if (state_r == ST_SCALE) begin
      scaled_r <= SCALED_W'(avg_r) * SCALED_W'(abld_pkg::ADC_REF_MV);
    end
    if (state_r == ST_PIN_EST) begin
      pin_est_r <= pin_prod[abld_pkg::PIN_SHIFT +: PIN_W];
    end
    if (state_r == ST_PIN_FIX) begin
      pin_r <= pin_est_r + PIN_W'(pin_rem >= PIN_DIV);
    end
    if (state_r == ST_BATT) begin
      batt_r <= BATT_W'(pin_r) * BATT_W'(abld_pkg::DIVIDER_SCALE);
    end
    if (emit_go) begin
      out_res_r.adc_average      <= avg_r;
      out_res_r.pin_mv           <= pin_r;
      out_res_r.battery_mv       <= batt_r;
      out_res_r.battery_low      <= (low_count_nxt >= cfg.confirm_readings);
      out_res_r.reading_sequence <= seq_r + SEQ_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      low_count_r <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_go) begin
        low_count_r <= low_count_nxt;
        seq_r       <= seq_r + SEQ_W'(1);
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `ABLD_ASSERT(avg_rem_bound, (state_r == ST_AVG_FIX) |-> (avg_rem < AVG_REM_LIM), "average estimate off by more than one")
  `ABLD_ASSERT(pin_rem_bound, (state_r == ST_PIN_FIX) |-> (pin_rem < PIN_REM_LIM), "pin estimate off by more than one")
  `ABLD_ASSERT(pin_range, out_valid_r |-> (out_res_r.pin_mv <= PIN_MAX), "pin millivolts out of range")
  `ABLD_ASSERT_ALWAYS(idle_after_reset, !rst_n |=> (state_r == ST_IDLE) && !out_valid_r, "back end not idle after reset")

endmodule
